[hw/rtl/reer_pkg.sv]
// Package for the ray endpoint extent recenter core: payload types, opcodes,
// controller command struct, CORDIC constants and shared arithmetic helpers.
// No dependencies.
`default_nettype none

package reer_pkg;

    localparam int MARGIN_W = 25;
    localparam int X_W      = 42;
    localparam int Z_W      = 34;
    localparam int STEP_W   = 5;
    localparam int GUARD_W  = 8;

    localparam logic [1:0] OP_ACC = 2'd0;
    localparam logic [1:0] OP_REC = 2'd1;
    localparam logic [1:0] OP_CLR = 2'd2;

    localparam logic [31:0]         CORDIC_GAIN  = 32'd2608131496;
    localparam logic [MARGIN_W-1:0] MARGIN_RESET = 25'd65536;

    typedef struct packed {
        logic [1:0]         opcode;
        logic signed [31:0] pose_x;
        logic signed [31:0] pose_y;
        logic signed [15:0] heading;
        logic signed [15:0] beam_angle;
        logic [30:0]        range;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] shifted_x;
        logic signed [31:0] shifted_y;
        logic [31:0]        extent_width;
        logic [31:0]        extent_height;
        logic               box_valid;
    } t_out_item;

    typedef struct packed {
        logic              load_item;
        logic              clear_box;
        logic              seed_box;
        logic              init_rot;
        logic              step;
        logic              rnd;
        logic              widen;
        logic              load_out;
        logic [STEP_W-1:0] step_idx;
    } t_dp_cmd;

    function automatic logic [29:0] atan_q32(input logic [STEP_W-1:0] idx);
        logic [29:0] v;
        case (idx)
            5'd0:    v = 30'h20000000;
            5'd1:    v = 30'h12E4051E;
            5'd2:    v = 30'h09FB385B;
            5'd3:    v = 30'h051111D4;
            5'd4:    v = 30'h028B0D43;
            5'd5:    v = 30'h0145D7E1;
            5'd6:    v = 30'h00A2F61E;
            5'd7:    v = 30'h00517C55;
            5'd8:    v = 30'h0028BE53;
            5'd9:    v = 30'h00145F2F;
            5'd10:   v = 30'h000A2F98;
            5'd11:   v = 30'h000517CC;
            5'd12:   v = 30'h00028BE6;
            5'd13:   v = 30'h000145F3;
            5'd14:   v = 30'h0000A2FA;
            5'd15:   v = 30'h0000517D;
            5'd16:   v = 30'h000028BE;
            5'd17:   v = 30'h0000145F;
            5'd18:   v = 30'h00000A30;
            5'd19:   v = 30'h00000518;
            5'd20:   v = 30'h0000028C;
            5'd21:   v = 30'h00000146;
            5'd22:   v = 30'h000000A3;
            5'd23:   v = 30'h00000051;
            default: v = 30'h0;
        endcase
        return v;
    endfunction

    function automatic logic [31:0] sat_s32(input logic signed [35:0] v);
        logic [31:0] r;
        if ((v[35:31] == 5'b00000) || (v[35:31] == 5'b11111)) begin
            r = v[31:0];
        end else if (v[35]) begin
            r = 32'h8000_0000;
        end else begin
            r = 32'h7FFF_FFFF;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/reer_ctrl.sv]
// Controller FSM for the ray endpoint extent recenter core.
// Sequences item load, CORDIC iterations, widening and result hand-off.
// Depends on reer_pkg.
`default_nettype none

module reer_ctrl
    import reer_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    input  wire logic [1:0] i_opcode,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output t_dp_cmd         o_cmd
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_ROT  = 3'd2;
    localparam logic [2:0] ST_RND  = 3'd3;
    localparam logic [2:0] ST_WID  = 3'd4;
    localparam logic [2:0] ST_EMIT = 3'd5;

    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(CORDIC_STEPS - 1);

    logic [2:0]        r_state, n_state;
    logic [STEP_W-1:0] r_cnt, n_cnt;
    logic              r_out_valid, n_out_valid;
    logic              accept;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign accept      = i_in_valid && o_in_ready;

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        o_cmd.step_idx = r_cnt;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    o_cmd.load_item = 1'b1;
                    case (i_opcode)
                        OP_ACC:  n_state = ST_MUL;
                        OP_REC:  n_state = ST_EMIT;
                        OP_CLR:  o_cmd.clear_box = 1'b1;
                        default: n_state = ST_IDLE;
                    endcase
                end
            end
            ST_MUL: begin
                o_cmd.seed_box = 1'b1;
                o_cmd.init_rot = 1'b1;
                n_cnt          = '0;
                n_state        = ST_ROT;
            end
            ST_ROT: begin
                o_cmd.step = 1'b1;
                if (r_cnt == LAST_STEP) begin
                    n_state = ST_RND;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_RND: begin
                o_cmd.rnd = 1'b1;
                n_state   = ST_WID;
            end
            ST_WID: begin
                o_cmd.widen = 1'b1;
                n_state     = ST_IDLE;
            end
            ST_EMIT: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/reer_dp.sv]
// Datapath for the ray endpoint extent recenter core: item latch, gain
// multiply, iterative CORDIC, endpoint saturation, box bounds, recenter math.
// Depends on reer_pkg.
`default_nettype none

module reer_dp
    import reer_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire t_dp_cmd             i_cmd,
    input  wire t_in_item            i_item,
    input  wire logic                i_cfg_we,
    input  wire logic [MARGIN_W-1:0] i_cfg_wdata,
    output t_out_item                o_out_data
);

    t_in_item                  r_item;
    logic [MARGIN_W-1:0]       r_margin;
    logic                      r_nonempty, n_nonempty;
    logic signed [31:0]        r_min_x, r_max_x, r_min_y, r_max_y;
    logic signed [31:0]        n_min_x, n_max_x, n_min_y, n_max_y;
    logic signed [X_W-1:0]     r_x, r_y, n_x, n_y;
    logic signed [Z_W-1:0]     r_z, n_z;
    logic signed [31:0]        r_ex, r_ey, n_ex, n_ey;
    t_out_item                 r_out, n_out;

    // gain multiply and quadrant fold
    logic signed [15:0]        ang, ang_f;
    logic                      fold;
    logic [62:0]               prod;
    logic signed [X_W-1:0]     x0;

    // rotation step
    logic signed [X_W-1:0]     xs, ys;
    logic signed [Z_W-1:0]     atn;

    // rounding
    logic signed [X_W-1:0]     xr, yr;
    logic signed [Z_W-1:0]     dx, dy;
    logic signed [35:0]        sum_x, sum_y;

    // recenter
    logic [32:0]               mid_sx, mid_sy;
    logic signed [31:0]        mid_x, mid_y;
    logic signed [35:0]        dif_x, dif_y;
    logic [33:0]               ext_w, ext_h;
    logic [33:0]               m2;

    always_comb begin
        ang   = r_item.heading + r_item.beam_angle;
        fold  = (ang > 16'sd16384) || (ang < -16'sd16384);
        ang_f = fold ? {~ang[15], ang[14:0]} : ang;
        prod  = 63'(r_item.range) * 63'(CORDIC_GAIN);
        x0    = {3'b000, prod[62:24]};

        xs  = r_x >>> i_cmd.step_idx;
        ys  = r_y >>> i_cmd.step_idx;
        atn = {{(Z_W-30){1'b0}}, atan_q32(i_cmd.step_idx)};

        xr    = r_x + X_W'(128);
        yr    = r_y + X_W'(128);
        dx    = xr[X_W-1:GUARD_W];
        dy    = yr[X_W-1:GUARD_W];
        sum_x = {{4{r_item.pose_x[31]}}, r_item.pose_x} + {{2{dx[Z_W-1]}}, dx};
        sum_y = {{4{r_item.pose_y[31]}}, r_item.pose_y} + {{2{dy[Z_W-1]}}, dy};

        mid_sx = {r_min_x[31], r_min_x} + {r_max_x[31], r_max_x};
        mid_sy = {r_min_y[31], r_min_y} + {r_max_y[31], r_max_y};
        mid_x  = mid_sx[32:1];
        mid_y  = mid_sy[32:1];
        dif_x  = {{4{r_item.pose_x[31]}}, r_item.pose_x} - {{4{mid_x[31]}}, mid_x};
        dif_y  = {{4{r_item.pose_y[31]}}, r_item.pose_y} - {{4{mid_y[31]}}, mid_y};
        m2     = {8'd0, r_margin, 1'b0};
        ext_w  = {{2{r_max_x[31]}}, r_max_x} - {{2{r_min_x[31]}}, r_min_x} + m2;
        ext_h  = {{2{r_max_y[31]}}, r_max_y} - {{2{r_min_y[31]}}, r_min_y} + m2;
    end

    always_comb begin
        n_x = r_x;
        n_y = r_y;
        n_z = r_z;
        if (i_cmd.init_rot) begin
            n_x = fold ? -x0 : x0;
            n_y = '0;
            n_z = {{(Z_W-32){ang_f[15]}}, ang_f, 16'd0};
        end else if (i_cmd.step) begin
            if (!r_z[Z_W-1]) begin
                n_x = r_x - ys;
                n_y = r_y + xs;
                n_z = r_z - atn;
            end else begin
                n_x = r_x + ys;
                n_y = r_y - xs;
                n_z = r_z + atn;
            end
        end
    end

    assign n_ex = sat_s32(sum_x);
    assign n_ey = sat_s32(sum_y);

    always_comb begin
        n_min_x    = r_min_x;
        n_max_x    = r_max_x;
        n_min_y    = r_min_y;
        n_max_y    = r_max_y;
        n_nonempty = r_nonempty;
        if (i_cmd.clear_box) begin
            n_min_x    = '0;
            n_max_x    = '0;
            n_min_y    = '0;
            n_max_y    = '0;
            n_nonempty = 1'b0;
        end else if (i_cmd.seed_box && !r_nonempty) begin
            n_min_x    = r_item.pose_x;
            n_max_x    = r_item.pose_x;
            n_min_y    = r_item.pose_y;
            n_max_y    = r_item.pose_y;
            n_nonempty = 1'b1;
        end else if (i_cmd.seed_box) begin
            if (r_item.pose_x < r_min_x) n_min_x = r_item.pose_x;
            if (r_item.pose_x > r_max_x) n_max_x = r_item.pose_x;
            if (r_item.pose_y < r_min_y) n_min_y = r_item.pose_y;
            if (r_item.pose_y > r_max_y) n_max_y = r_item.pose_y;
        end else if (i_cmd.widen) begin
            if (r_ex < r_min_x) n_min_x = r_ex;
            if (r_ex > r_max_x) n_max_x = r_ex;
            if (r_ey < r_min_y) n_min_y = r_ey;
            if (r_ey > r_max_y) n_max_y = r_ey;
        end
    end

    always_comb begin
        n_out = r_out;
        if (i_cmd.load_out) begin
            if (r_nonempty) begin
                n_out.shifted_x     = sat_s32(dif_x);
                n_out.shifted_y     = sat_s32(dif_y);
                n_out.extent_width  = (ext_w[33:32] != 2'b00) ? 32'hFFFF_FFFF : ext_w[31:0];
                n_out.extent_height = (ext_h[33:32] != 2'b00) ? 32'hFFFF_FFFF : ext_h[31:0];
                n_out.box_valid     = 1'b1;
            end else begin
                n_out.shifted_x     = r_item.pose_x;
                n_out.shifted_y     = r_item.pose_y;
                n_out.extent_width  = '0;
                n_out.extent_height = '0;
                n_out.box_valid     = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_margin   <= MARGIN_RESET;
            r_nonempty <= 1'b0;
            r_min_x    <= '0;
            r_max_x    <= '0;
            r_min_y    <= '0;
            r_max_y    <= '0;
        end else begin
            if (i_cfg_we) begin
                r_margin <= i_cfg_wdata;
            end
            r_nonempty <= n_nonempty;
            r_min_x    <= n_min_x;
            r_max_x    <= n_max_x;
            r_min_y    <= n_min_y;
            r_max_y    <= n_max_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_item <= i_item;
        end
        if (i_cmd.rnd) begin
            r_ex <= n_ex;
            r_ey <= n_ey;
        end
        r_x     <= n_x;
        r_y     <= n_y;
        r_z     <= n_z;
        r_out   <= n_out;
    end

    assign o_out_data = r_out;

endmodule

`default_nettype wire

[hw/rtl/ray_endpoint_extent_recenter_core.sv]
// Ray endpoint extent recenter core. Accumulate: no new transfer is taken until the
// one-step-per-cycle CORDIC loop and the rounding and widening states are done.
// Recenter: EMIT loads the result, waiting while an older one stalls; a clear stays in IDLE.
// Reset is synchronous, active low: box empty, margin 1.0 m, no result pending.
// Depends on reer_pkg, reer_ctrl, reer_dp.
`default_nettype none

module ray_endpoint_extent_recenter_core
    import reer_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire t_in_item            i_in_data,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output t_out_item                o_out_data,
    input  wire logic                i_cfg_we,
    input  wire logic [MARGIN_W-1:0] i_cfg_wdata
);

    t_dp_cmd cmd;

    reer_ctrl #(
        .CORDIC_STEPS(CORDIC_STEPS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_opcode    (i_in_data.opcode),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd)
    );

    reer_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_item      (i_in_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire

[hw/rtl/reer_checker.sv]
// Port-level checker for the ray endpoint extent recenter core, with bind.
// Depends on reer_pkg.
`default_nettype none

module reer_checker
    import reer_pkg::*;
(
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      i_in_valid,
    input wire logic      o_in_ready,
    input wire t_in_item  i_in_data,
    input wire logic      o_out_valid,
    input wire logic      i_out_ready,
    input wire t_out_item o_out_data
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");

    a_empty_extent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.box_valid |->
            o_out_data.extent_width == 32'd0 && o_out_data.extent_height == 32'd0)
        else $error("empty box reported nonzero extent");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_in_ready)
        else $error("reset did not clear handshake state");

    a_acc_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_in_data.opcode == OP_ACC |=> !o_in_ready)
        else $error("accumulate transfer did not occupy the core");

endmodule

bind ray_endpoint_extent_recenter_core reer_checker u_reer_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

`default_nettype wire

[test/reer_checker.sv]
// Checker for ray_endpoint_extent_recenter_core: watches the input, output and
// config ports, predicts each recenter result and compares it field by field.
// Depends on reer_pkg for the payload types, opcodes and the CORDIC gain.
module reer_tb_checker
    import reer_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    input  wire logic                i_in_ready,
    input  wire t_in_item            i_in_data,
    input  wire logic                i_out_valid,
    input  wire logic                i_out_ready,
    input  wire t_out_item           i_out_data,
    input  wire logic                i_cfg_we,
    input  wire logic [MARGIN_W-1:0] i_cfg_wdata,
    output int                       o_fail_count,
    output int                       o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint S32_MAX = 64'sd2147483647;
    localparam longint S32_MIN = -64'sd2147483648;
    localparam longint U32_MAX = 64'sd4294967295;

    longint arctan_q32 [24] = '{
        64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
        64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
        64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
        64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
        64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051
    };

    logic [MARGIN_W-1:0] margin_q;
    logic signed [31:0]  lo_x, hi_x, lo_y, hi_y;
    logic                box_full;
    t_out_item           extent_q [$];
    t_out_item           want;
    int                  fail_count;

    function automatic logic signed [31:0] clamp_s32(input longint v);
        if (v > S32_MAX) return 32'h7FFF_FFFF;
        if (v < S32_MIN) return 32'h8000_0000;
        return v[31:0];
    endfunction

    function automatic logic [31:0] clamp_u32(input longint v);
        if (v < 0) return 32'h0;
        if (v > U32_MAX) return 32'hFFFF_FFFF;
        return v[31:0];
    endfunction

    // Rotate (range, 0) by a binary angle; offsets come back in Q16.16.
    task automatic beam_offset(input logic [30:0] rng, input logic signed [15:0] ang,
                               output longint dx, output longint dy);
        longint unsigned prod;
        longint x, y, z, xs, ys;
        logic signed [15:0] a;
        prod = 64'(rng) * 64'(CORDIC_GAIN);
        x = longint'(prod >> 24);
        y = 0;
        a = ang;
        if (a > 16'sd16384 || a < -16'sd16384) begin
            x = -x;
            a[15] = ~a[15];
        end
        z = longint'(a) * 65536;
        for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
                x = x - ys;
                y = y + xs;
                z = z - arctan_q32[i];
            end else begin
                x = x + ys;
                y = y - xs;
                z = z + arctan_q32[i];
            end
        end
        dx = (x + 128) >>> 8;
        dy = (y + 128) >>> 8;
    endtask

    task automatic stretch(input logic signed [31:0] px, input logic signed [31:0] py);
        if (px < lo_x) lo_x = px;
        if (px > hi_x) hi_x = px;
        if (py < lo_y) lo_y = py;
        if (py > hi_y) hi_y = py;
    endtask

    task automatic absorb_ray(input t_in_item it);
        longint dx, dy;
        logic signed [31:0] ex, ey;
        logic signed [15:0] ang;
        ang = it.heading + it.beam_angle;
        beam_offset(it.range, ang, dx, dy);
        ex = clamp_s32(longint'(it.pose_x) + dx);
        ey = clamp_s32(longint'(it.pose_y) + dy);
        if (!box_full) begin
            lo_x = it.pose_x;
            hi_x = it.pose_x;
            lo_y = it.pose_y;
            hi_y = it.pose_y;
            box_full = 1'b1;
        end else begin
            stretch(it.pose_x, it.pose_y);
        end
        stretch(ex, ey);
    endtask

    function automatic t_out_item recenter_pose(input t_in_item it);
        t_out_item r;
        longint mid_x, mid_y, pad;
        r.shifted_x     = it.pose_x;
        r.shifted_y     = it.pose_y;
        r.extent_width  = '0;
        r.extent_height = '0;
        r.box_valid     = box_full;
        if (box_full) begin
            mid_x = (longint'(lo_x) + longint'(hi_x)) >>> 1;
            mid_y = (longint'(lo_y) + longint'(hi_y)) >>> 1;
            pad   = 2 * longint'(margin_q);
            r.shifted_x     = clamp_s32(longint'(it.pose_x) - mid_x);
            r.shifted_y     = clamp_s32(longint'(it.pose_y) - mid_y);
            r.extent_width  = clamp_u32(longint'(hi_x) - longint'(lo_x) + pad);
            r.extent_height = clamp_u32(longint'(hi_y) - longint'(lo_y) + pad);
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            margin_q   = MARGIN_RESET;
            lo_x       = '0;
            hi_x       = '0;
            lo_y       = '0;
            hi_y       = '0;
            box_full   = 1'b0;
            fail_count = 0;
            extent_q.delete();
        end else begin
            if (i_cfg_we) margin_q = i_cfg_wdata;
            if (i_out_valid && i_out_ready) begin
                if (extent_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%t: result with none expected: x=%0d y=%0d w=%0d h=%0d v=%0b",
                                 $realtime, $signed(i_out_data.shifted_x),
                                 $signed(i_out_data.shifted_y), i_out_data.extent_width,
                                 i_out_data.extent_height, i_out_data.box_valid);
                end else begin
                    want = extent_q.pop_front();
                    if (i_out_data.shifted_x !== want.shifted_x
                            || i_out_data.shifted_y !== want.shifted_y
                            || i_out_data.extent_width !== want.extent_width
                            || i_out_data.extent_height !== want.extent_height
                            || i_out_data.box_valid !== want.box_valid) begin
                        fail_count++;
                        if (fail_count <= 10) begin
                            $display("%t: mismatch exp x=%0d y=%0d w=%0d h=%0d v=%0b",
                                     $realtime, $signed(want.shifted_x),
                                     $signed(want.shifted_y), want.extent_width,
                                     want.extent_height, want.box_valid);
                            $display("%t:          got x=%0d y=%0d w=%0d h=%0d v=%0b",
                                     $realtime, $signed(i_out_data.shifted_x),
                                     $signed(i_out_data.shifted_y), i_out_data.extent_width,
                                     i_out_data.extent_height, i_out_data.box_valid);
                        end
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                case (i_in_data.opcode)
                    OP_ACC: absorb_ray(i_in_data);
                    OP_REC: extent_q = {extent_q, recenter_pose(i_in_data)};
                    OP_CLR: begin
                        lo_x     = '0;
                        hi_x     = '0;
                        lo_y     = '0;
                        hi_y     = '0;
                        box_full = 1'b0;
                    end
                    default: ;
                endcase
            end
        end
        o_fail_count = fail_count;
        o_pending    = extent_q.size();
    end

endmodule

[test/tb_ray_endpoint_extent_recenter_core.sv]
// Testbench top for ray_endpoint_extent_recenter_core: drives directed and random
// rays, recenters and clears under several margins, with random idling on both sides.
// Depends on reer_pkg, reer_tb_checker and the core RTL.
module tb_ray_endpoint_extent_recenter_core import reer_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          CORDIC_STEPS = 16;
    localparam int          DRAIN_CYCLES = CORDIC_STEPS + 12;
    localparam int          HOLD_CYCLES  = 300;
    localparam int          CYCLE_LIMIT  = 200000;
    localparam logic [1:0]  OP_SPARE     = 2'd3;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    t_in_item            in_data;
    logic                out_valid;
    logic                out_ready;
    t_out_item           out_data;
    logic                cfg_we;
    logic [MARGIN_W-1:0] cfg_wdata;
    int                  fail_count;
    int                  pending;
    int                  cycle_count;
    bit                  steady;
    int                  holds_asked;
    int                  holds_done;

    ray_endpoint_extent_recenter_core #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    reer_tb_checker #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_data   (out_data),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    initial cycle_count = 0;
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic t_in_item mk(input logic [1:0] op, input logic signed [31:0] px,
                                    input logic signed [31:0] py,
                                    input logic signed [15:0] hd,
                                    input logic signed [15:0] bm, input logic [30:0] rg);
        t_in_item r;
        r.opcode     = op;
        r.pose_x     = px;
        r.pose_y     = py;
        r.heading    = hd;
        r.beam_angle = bm;
        r.range      = rg;
        return r;
    endfunction

    function automatic logic signed [31:0] rand_pos();
        int unsigned pick;
        pick = $urandom_range(0, 19);
        if (pick == 0) return $urandom;
        if (pick == 1) return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
        return $signed($urandom) >>> 6;
    endfunction

    function automatic logic [30:0] rand_range();
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (pick == 0) return 31'($urandom);
        if (pick == 1) return '0;
        return 31'($urandom_range(0, 32'h01FF_FFFF));
    endfunction

    function automatic t_in_item random_item();
        int unsigned pick;
        logic [1:0]  op;
        pick = $urandom_range(0, 99);
        if (pick < 58)      op = OP_ACC;
        else if (pick < 90) op = OP_REC;
        else if (pick < 97) op = OP_CLR;
        else                op = OP_SPARE;
        return mk(op, rand_pos(), rand_pos(), 16'($urandom), 16'($urandom), rand_range());
    endfunction

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic offer(input t_in_item it);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_margin(input logic [MARGIN_W-1:0] v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Receiver: random stall per transfer, plus one long hold-off on request.
    initial begin
        int stall;
        out_ready  = 1'b0;
        holds_done = 0;
        @(negedge clk);
        forever begin
            stall = steady ? 0 : $urandom_range(0, 3);
            if (holds_done != holds_asked) begin
                stall = HOLD_CYCLES;
                holds_done++;
            end
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            @(negedge clk);
        end
    end

    initial begin
        logic [MARGIN_W-1:0] margin_set [6];
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        in_data     = '0;
        cfg_we      = 1'b0;
        cfg_wdata   = '0;
        steady      = 1'b0;
        holds_asked = 0;
        margin_set  = '{25'd0, 25'd16777216, 25'd65536, 25'($urandom_range(0, 16777216)),
                        25'd1, 25'($urandom_range(0, 16777216))};
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: empty box, angle wrap and quadrant edges, saturation
        offer(mk(OP_REC, 32'sh7FFF_FFFF, 32'sh8000_0000, 16'sh0000, 16'sh0000, 31'd0));
        offer(mk(OP_CLR, 32'sh0, 32'sh0, 16'sh0, 16'sh0, 31'd0));
        offer(mk(OP_ACC, 32'sh0, 32'sh0, 16'sh0, 16'sh0, 31'd0));
        offer(mk(OP_REC, 32'sh0, 32'sh0, 16'sh0, 16'sh0, 31'd0));
        offer(mk(OP_ACC, 32'sh0064_0000, -32'sh0032_0000, 16'sh7FFF, 16'sh0001,
                 31'h000A_0000));
        offer(mk(OP_ACC, 32'sh0001_0000, 32'sh0002_0000, 16'sh4000, 16'sh0000,
                 31'h0005_0000));
        offer(mk(OP_ACC, -32'sh0001_0000, 32'sh0003_0000, 16'sh4001, 16'sh0000,
                 31'h0005_0000));
        offer(mk(OP_ACC, 32'sh0004_0000, -32'sh0001_0000, -16'sh4000, 16'sh0000,
                 31'h0007_0000));
        offer(mk(OP_ACC, -32'sh0004_0000, -32'sh0002_0000, -16'sh4001, 16'sh0000,
                 31'h0007_0000));
        offer(mk(OP_REC, 32'sh0010_0000, -32'sh0010_0000, 16'sh0, 16'sh0, 31'd0));
        offer(mk(OP_ACC, 32'sh0, 32'sh0, 16'sh8000, 16'sh8000, 31'h7FFF_FFFF));
        offer(mk(OP_ACC, 32'sh0, 32'sh0, 16'sh1234, 16'sh7FFF, 31'h7FFF_FFFF));
        offer(mk(OP_REC, 32'sh0, 32'sh0, 16'sh0, 16'sh0, 31'd0));
        offer(mk(OP_ACC, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 16'sh0000, 16'sh1000,
                 31'h7FFF_FFFF));
        offer(mk(OP_ACC, 32'sh8000_0000, 32'sh8000_0000, 16'sh8000, 16'shF000,
                 31'h7FFF_FFFF));
        offer(mk(OP_REC, 32'sh7FFF_FFFF, 32'sh8000_0000, 16'sh0, 16'sh0, 31'd0));
        offer(mk(OP_SPARE, 32'shFFFF_FFFF, 32'shFFFF_FFFF, 16'shFFFF, 16'shFFFF,
                 31'h7FFF_FFFF));
        offer(mk(OP_REC, 32'sh8000_0000, 32'sh7FFF_FFFF, 16'sh0, 16'sh0, 31'd0));
        offer(mk(OP_CLR, 32'sh0, 32'sh0, 16'sh0, 16'sh0, 31'd0));
        offer(mk(OP_REC, rand_pos(), rand_pos(), 16'sh0, 16'sh0, 31'd0));
        offer(mk(OP_ACC, rand_pos(), rand_pos(), 16'($urandom), 16'sh0, rand_range()));
        offer(mk(OP_REC, rand_pos(), rand_pos(), 16'sh0, 16'sh0, 31'd0));
        drain();

        for (int p = 0; p < 6; p++) begin
            write_margin(margin_set[p]);
            steady = (p == 2);
            if (p == 3) begin
                holds_asked++;
                repeat (12) offer(mk(OP_REC, rand_pos(), rand_pos(), 16'($urandom),
                                     16'($urandom), rand_range()));
            end
            repeat (125) offer(random_item());
            drain();
        end

        if (fail_count == 0 && pending == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

[sim.f]
hw/rtl/reer_pkg.sv
hw/rtl/reer_ctrl.sv
hw/rtl/reer_dp.sv
hw/rtl/ray_endpoint_extent_recenter_core.sv
hw/rtl/reer_checker.sv
test/reer_checker.sv
test/tb_ray_endpoint_extent_recenter_core.sv
